// ----- sv/vssl_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vssl_pkg - shared definitions for the vector setpoint step limiter
// Register indexes, reset values, opcodes, sequencer states and helpers.
// ---------------------------------------------------------------------------
package vssl_pkg;

    // default parameter values
    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_CAP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_MODE = 2'd2;

    localparam int SPEED_W = 32;
    localparam int TICK_W  = 16;

    localparam logic [SPEED_W-1:0] SPEED_CAP_RST   = 32'd98304;
    localparam logic [TICK_W-1:0]  TICK_PERIOD_RST = 16'd655;
    localparam logic               MODE_RST        = 1'b0;

    localparam logic MODE_PLANAR = 1'b0;

    // beat opcodes
    localparam logic OP_SET_TARGET = 1'b0;
    localparam logic OP_TICK       = 1'b1;

    // port width of a coordinate
    localparam int PORT_W = 32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LIM,
        ST_LIM2,
        ST_SQ,
        ST_DECIDE,
        ST_SQRT,
        ST_STEP_MUL,
        ST_STEP_DIV,
        ST_FINISH
    } vssl_state_t;

    function automatic int max2(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ----- sv/vector_setpoint_step_limiter_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vector_setpoint_step_limiter_core - Euclidean position step limiter
// Holds a target and the last output; each tick moves towards the target by
// at most the speed cap times the tick period.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries opcode and target_x/y/z.
//   A set-target beat stores the target and gives no result.
//   A tick beat produces one result beat (out_x/y/z, was_limited) on the
//   output channel (out_valid/out_ready).
//   Config writes (cfg_we, cfg_index, cfg_data) are taken at any clock edge.
// Datapath (MW = max(COORD_BITS, 48-FRAC_BITS, 32)):
//   A tick measures 2 or 3 axes, by distance mode, on one shared MW-bit
//   bit-serial multiplier, a root unit and a restoring divider. The input
//   accepts only between ticks, one tick at a time; the next beat can be
//   taken the cycle after the result is registered.
// Reset: target and last output clear to zero, registers take defaults.
// Stall: a finished result waits in the output register; set-target beats
//   are still accepted, a following tick holds in its last step until the
//   output register is free.
// ---------------------------------------------------------------------------
module vector_setpoint_step_limiter_core #(
    parameter int COORD_BITS = vssl_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = vssl_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_we,
    input  logic [vssl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vssl_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              opcode,
    input  logic signed [vssl_pkg::PORT_W-1:0] target_x,
    input  logic signed [vssl_pkg::PORT_W-1:0] target_y,
    input  logic signed [vssl_pkg::PORT_W-1:0] target_z,
    // output channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [vssl_pkg::PORT_W-1:0] out_x,
    output logic signed [vssl_pkg::PORT_W-1:0] out_y,
    output logic signed [vssl_pkg::PORT_W-1:0] out_z,
    output logic                              was_limited
);
    import vssl_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int F      = FRAC_BITS;
    localparam int PROD_W = SPEED_W + TICK_W;
    localparam int LIM_W  = PROD_W - F;
    localparam int MW     = max2(max2(C, LIM_W), SPEED_W);
    localparam int D2_W   = 2 * C;
    localparam int CMP_W  = max2(D2_W, 2 * LIM_W);
    localparam int NUM_W  = C + LIM_W;
    localparam int SAT_W  = max2(max2(C, LIM_W) + 2, PORT_W);
    localparam int OUT_W  = max2(C, PORT_W);

    vssl_state_t state_reg, state_next;
    logic        go_reg, go_next;

    logic [SPEED_W-1:0] speed_cap_reg;
    logic [TICK_W-1:0]  tick_reg;
    logic               mode_reg;

    logic [C-1:0]     goal_reg [3];
    logic [C-1:0]     last_reg [3];
    logic [C-1:0]     res_reg  [3];
    logic [1:0]       axis_reg;
    logic [LIM_W-1:0] lim_reg;
    logic [2*LIM_W-1:0] lim2_reg;
    logic [D2_W-1:0]  dist2_reg;
    logic             clipped_reg;

    logic             out_valid_reg;
    logic [PORT_W-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic             was_limited_reg;

    logic [C-1:0]     d_all [3];
    logic [C-1:0]     in_sat [3];
    logic [C-1:0]     d_sel;
    logic [C-1:0]     mag_sel;
    logic [1:0]       last_axis;
    logic             lim_zero;
    logic             in_limit;
    logic             out_free;
    logic [SAT_W-1:0] step_sum;
    logic [C-1:0]     step_sat;

    logic             mul_start, mul_done;
    logic [MW-1:0]    mul_a, mul_b;
    logic [2*MW-1:0]  mul_prod;
    logic             sqrt_start, sqrt_done;
    logic [C-1:0]     root_dist;
    logic             div_start, div_done;
    logic [NUM_W-1:0] div_q;

    // saturate a sign-extended value to the coordinate width
    function automatic logic [C-1:0] sat_c(input logic [SAT_W-1:0] v);
        logic [SAT_W-C:0] top;
        top = v[SAT_W-1:C-1];
        if ((&top) || !(|top))
            return v[C-1:0];
        else if (v[SAT_W-1])
            return {1'b1, {(C-1){1'b0}}};
        else
            return {1'b0, {(C-1){1'b1}}};
    endfunction

    // deltas, input saturation and per-axis selection
    always_comb
    begin
        in_sat[0] = sat_c(SAT_W'(target_x));
        in_sat[1] = sat_c(SAT_W'(target_y));
        in_sat[2] = sat_c(SAT_W'(target_z));
        for (int i = 0; i < 3; i++)
        begin
            d_all[i] = sat_c(SAT_W'($signed(goal_reg[i])) - SAT_W'($signed(last_reg[i])));
        end
        d_sel     = d_all[axis_reg];
        mag_sel   = d_sel[C-1] ? (~d_sel + 1'b1) : d_sel;
        last_axis = (mode_reg == MODE_PLANAR) ? 2'd1 : 2'd2;
        lim_zero  = (lim_reg == '0);
        in_limit  = (CMP_W'(dist2_reg) < CMP_W'(lim2_reg));
        out_free  = !out_valid_reg || out_ready;
    end

    // moved axis: last +/- quotient, saturated
    always_comb
    begin
        if (d_sel[C-1])
            step_sum = SAT_W'($signed(last_reg[axis_reg])) - SAT_W'(div_q[LIM_W-1:0]);
        else
            step_sum = SAT_W'($signed(last_reg[axis_reg])) + SAT_W'(div_q[LIM_W-1:0]);
        step_sat = sat_c(step_sum);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid && (opcode == OP_TICK))
                    state_next = ST_LIM;
            ST_LIM:
                if (mul_done)
                    state_next = ST_LIM2;
            ST_LIM2:
                if (mul_done)
                    state_next = ST_SQ;
            ST_SQ:
                if (mul_done && (axis_reg == last_axis))
                    state_next = ST_DECIDE;
            ST_DECIDE:
                state_next = (lim_zero || in_limit) ? ST_FINISH : ST_SQRT;
            ST_SQRT:
                if (sqrt_done)
                    state_next = ST_STEP_MUL;
            ST_STEP_MUL:
                if (mul_done)
                    state_next = ST_STEP_DIV;
            ST_STEP_DIV:
                if (div_done)
                    state_next = (axis_reg == last_axis) ? ST_FINISH : ST_STEP_MUL;
            ST_FINISH:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase

        // kick a unit on entry to its state, and again per axis of squares
        go_next = ((state_next == ST_LIM) || (state_next == ST_LIM2) ||
                   (state_next == ST_SQ) || (state_next == ST_SQRT) ||
                   (state_next == ST_STEP_MUL) || (state_next == ST_STEP_DIV)) &&
                  ((state_next != state_reg) || mul_done);
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready   = (state_reg == ST_IDLE);
        mul_start  = 1'b0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        mul_a      = MW'(mag_sel);
        mul_b      = MW'(mag_sel);
        unique case (state_reg)
            ST_LIM:
            begin
                mul_start = go_reg;
                mul_a     = MW'(speed_cap_reg);
                mul_b     = MW'(tick_reg);
            end
            ST_LIM2:
            begin
                mul_start = go_reg;
                mul_a     = MW'(lim_reg);
                mul_b     = MW'(lim_reg);
            end
            ST_SQ:
                mul_start = go_reg;
            ST_SQRT:
                sqrt_start = go_reg;
            ST_STEP_MUL:
            begin
                mul_start = go_reg;
                mul_b     = MW'(lim_reg);
            end
            ST_STEP_DIV:
                div_start = go_reg;
            default:
            begin
            end
        endcase
    end

    // shared units
    vssl_mul #(.W(MW)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    vssl_sqrt #(.IN_W(D2_W)) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (dist2_reg),
        .done  (sqrt_done),
        .root  (root_dist)
    );

    vssl_div #(.N_W(NUM_W), .D_W(C)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_prod[NUM_W-1:0]),
        .divisor  (root_dist),
        .done     (div_done),
        .quotient (div_q)
    );

    // state, configuration and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            go_reg        <= 1'b0;
            speed_cap_reg <= SPEED_CAP_RST;
            tick_reg      <= TICK_PERIOD_RST;
            mode_reg      <= MODE_RST;
            out_valid_reg <= 1'b0;
            axis_reg      <= '0;
            for (int i = 0; i < 3; i++)
            begin
                goal_reg[i] <= '0;
                last_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            go_reg    <= go_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SPEED_CAP:     speed_cap_reg <= cfg_data[SPEED_W-1:0];
                    CFG_TICK_PERIOD:   tick_reg      <= cfg_data[TICK_W-1:0];
                    CFG_DISTANCE_MODE: mode_reg      <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end

            // result register: load on finish, clear once taken
            if ((state_reg == ST_FINISH) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                    if (in_valid)
                    begin
                        if (opcode == OP_SET_TARGET)
                        begin
                            for (int i = 0; i < 3; i++)
                                goal_reg[i] <= in_sat[i];
                        end
                        else
                        begin
                            axis_reg  <= '0;
                            dist2_reg <= '0;
                        end
                    end
                ST_LIM:
                    if (mul_done)
                        lim_reg <= mul_prod[F +: LIM_W];
                ST_LIM2:
                    if (mul_done)
                        lim2_reg <= mul_prod[2*LIM_W-1:0];
                ST_SQ:
                    if (mul_done)
                    begin
                        dist2_reg <= dist2_reg + mul_prod[D2_W-1:0];
                        axis_reg  <= axis_reg + 1'b1;
                    end
                ST_DECIDE:
                begin
                    axis_reg <= '0;
                    if (lim_zero)
                    begin
                        res_reg     <= last_reg;
                        clipped_reg <= (dist2_reg != '0);
                    end
                    else if (in_limit)
                    begin
                        res_reg     <= goal_reg;
                        clipped_reg <= 1'b0;
                    end
                    else
                    begin
                        res_reg     <= last_reg;
                        clipped_reg <= 1'b1;
                    end
                end
                ST_STEP_DIV:
                    if (div_done)
                    begin
                        res_reg[axis_reg] <= step_sat;
                        axis_reg          <= axis_reg + 1'b1;
                    end
                ST_FINISH:
                    if (out_free)
                    begin
                        out_x_reg       <= PORT_W'(OUT_W'($signed(res_reg[0])));
                        out_y_reg       <= PORT_W'(OUT_W'($signed(res_reg[1])));
                        out_z_reg       <= PORT_W'(OUT_W'($signed(res_reg[2])));
                        was_limited_reg <= clipped_reg;
                        last_reg        <= res_reg;
                    end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign out_z       = out_z_reg;
    assign was_limited = was_limited_reg;

endmodule

// ----- sv/vssl_mul.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vssl_mul - bit-serial shift-add multiplier
// Unsigned W x W product, one multiplier bit per cycle, done pulse at end.
// ---------------------------------------------------------------------------
module vssl_mul #(
    parameter int W = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    output logic           done,
    output logic [2*W-1:0] prod
);
    localparam int CW = $clog2(W);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  a_reg;
    logic [W-1:0]  hi_reg;
    logic [W-1:0]  lo_reg;
    logic [W:0]    sum_next;

    // add the multiplicand when the current multiplier bit is set
    always_comb
    begin
        sum_next = lo_reg[0] ? ({1'b0, hi_reg} + {1'b0, a_reg}) : {1'b0, hi_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // payload shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum_next[W:1];
            lo_reg <= {sum_next[0], lo_reg[W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = {hi_reg, lo_reg};

endmodule

// ----- sv/vssl_sqrt.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vssl_sqrt - digit-by-digit integer square root
// Floor root of an IN_W-bit value, one root bit per cycle.
// ---------------------------------------------------------------------------
module vssl_sqrt #(
    parameter int IN_W = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [IN_W-1:0]   value,
    output logic              done,
    output logic [IN_W/2-1:0] root
);
    localparam int R  = IN_W / 2;
    localparam int CW = $clog2(R);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [IN_W-1:0] n_reg;
    logic [R:0]    rem_reg;
    logic [R-1:0]  root_reg;
    logic [R+2:0]  t_next;
    logic [R+2:0]  trial_next;
    logic [R+2:0]  diff_next;
    logic          ge_next;

    // bring down two bits, try root*4+1
    always_comb
    begin
        t_next     = {rem_reg, n_reg[IN_W-1 -: 2]};
        trial_next = {1'b0, root_reg, 2'b01};
        diff_next  = t_next - trial_next;
        ge_next    = (t_next >= trial_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(R - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg    <= value;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            n_reg    <= {n_reg[IN_W-3:0], 2'b00};
            rem_reg  <= ge_next ? diff_next[R:0] : t_next[R:0];
            root_reg <= {root_reg[R-2:0], ge_next};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- sv/vssl_div.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vssl_div - restoring divider
// Unsigned N_W-bit dividend over D_W-bit divisor, one quotient bit a cycle.
// ---------------------------------------------------------------------------
module vssl_div #(
    parameter int N_W = 64,
    parameter int D_W = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           done,
    output logic [N_W-1:0] quotient
);
    localparam int CW = $clog2(N_W);

    logic           busy_reg;
    logic           done_reg;
    logic [CW-1:0]  cnt_reg;
    logic [N_W-1:0] n_reg;
    logic [D_W-1:0] d_reg;
    logic [D_W-1:0] rem_reg;
    logic [D_W:0]   t_next;
    logic [D_W:0]   diff_next;
    logic           ge_next;

    // shift in the next dividend bit and try a subtract
    always_comb
    begin
        t_next    = {rem_reg, n_reg[N_W-1]};
        diff_next = t_next - {1'b0, d_reg};
        ge_next   = (t_next >= {1'b0, d_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(N_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= dividend;
            d_reg   <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            n_reg   <= {n_reg[N_W-2:0], ge_next};
            rem_reg <= ge_next ? diff_next[D_W-1:0] : t_next[D_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = n_reg;

endmodule
